>>> src/tmdf_pkg.sv
// Shared constants and control types of the trimmed mean distance filter.
package tmdf_pkg;

  localparam int unsigned NumSamples = 5;
  localparam int unsigned FrameLen   = 8;

  localparam logic [7:0] HdrByte  = 8'h55;
  localparam logic [7:0] CmdByte  = 8'h04;
  localparam logic [7:0] SubByte  = 8'h04;
  localparam logic [7:0] ZeroByte = 8'h00;
  localparam logic [7:0] TrlByte  = 8'hBB;

  // floor(x / 3) = (x * Recip3) >> Recip3Shift for every x below 2**19.
  localparam logic [17:0] Recip3      = 18'd174763;
  localparam int unsigned Recip3Shift = 19;
  // (x * Recip100) >> Recip100Shift is floor(x / 100) or one less for x < 2**16.
  localparam logic [15:0] Recip100      = 16'd41943;
  localparam int unsigned Recip100Shift = 22;
  localparam logic [6:0]  Hundred       = 7'd100;

  // Frame byte positions.
  localparam logic [2:0] PosHdr  = 3'd0;
  localparam logic [2:0] PosCmd  = 3'd1;
  localparam logic [2:0] PosSub  = 3'd2;
  localparam logic [2:0] PosZero = 3'd3;
  localparam logic [2:0] PosHund = 3'd4;
  localparam logic [2:0] PosRem  = 3'd5;
  localparam logic [2:0] PosChk  = 3'd6;
  localparam logic [2:0] PosTrl  = 3'd7;

  typedef struct packed {
    logic       load_sample;   // shift an accepted word into the store
    logic       capture_mode;  // latch the mode bit of the fifth word
    logic       scan_first;    // start min, max and sum with the oldest sample
    logic       scan_step;     // fold the oldest sample in and rotate the store
    logic       mid_en;        // middle sum = sum - min - max
    logic       div_en;        // multiply by the reciprocal of three
    logic       split_en;      // take the mean out of the product
    logic       hund_en;       // multiply by the reciprocal of one hundred
    logic       fix_en;        // correct quotient and remainder, saturate
    logic [2:0] byte_idx;      // frame byte being presented
  } tmdf_cmd_t;

  typedef struct packed {
    logic show_value;          // 1: a single value word, 0: a display frame
  } tmdf_status_t;

endpackage

>>> src/tmdf_datapath.sv
// Datapath: sample store, min/max/sum scan, reciprocal divisions and output mux.
module tmdf_datapath
  import tmdf_pkg::*;
(
  input  logic         clk,
  input  tmdf_cmd_t    cmd,
  output tmdf_status_t status,
  input  logic [15:0]  in_sample_distance,
  input  logic         in_show_on_display,
  output logic [7:0]   out_frame_byte,
  output logic [15:0]  out_filtered_distance,
  output logic         out_is_frame
);

  logic [15:0] store_r [NumSamples];
  logic [18:0] sum_r;
  logic [15:0] min_r;
  logic [15:0] max_r;
  logic [17:0] mid_r;
  logic [35:0] prod3_r;
  logic [15:0] mean_r;
  logic [31:0] prod100_r;
  logic [7:0]  hund_r;
  logic [7:0]  rem_r;
  logic        mode_r;

  logic [15:0] oldest;
  logic [9:0]  quo;
  logic [16:0] quo_x100;
  logic [16:0] rem_raw;
  logic [9:0]  quo_fix;
  logic [7:0]  rem_fix;
  logic [7:0]  chk;
  logic [7:0]  frame_sel;

  assign oldest = store_r[0];

  // The store is a shift line; the scan rotates it so the oldest tap sees every sample.
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      for (int i = 0; i < NumSamples - 1; i++) begin
        store_r[i] <= store_r[i+1];
      end
      store_r[NumSamples-1] <= in_sample_distance;
    end else if (cmd.scan_step) begin
      for (int i = 0; i < NumSamples - 1; i++) begin
        store_r[i] <= store_r[i+1];
      end
      store_r[NumSamples-1] <= oldest;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_mode) begin
      mode_r <= in_show_on_display;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_first) begin
      sum_r <= {3'd0, oldest};
      min_r <= oldest;
      max_r <= oldest;
    end else if (cmd.scan_step) begin
      sum_r <= sum_r + {3'd0, oldest};
      if (oldest < min_r) begin
        min_r <= oldest;
      end
      if (oldest > max_r) begin
        max_r <= oldest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mid_en) begin
      mid_r <= 18'(sum_r - {3'd0, min_r} - {3'd0, max_r});
    end
    if (cmd.div_en) begin
      prod3_r <= mid_r * Recip3;
    end
    if (cmd.split_en) begin
      mean_r <= prod3_r[Recip3Shift +: 16];
    end
    if (cmd.hund_en) begin
      prod100_r <= mean_r * Recip100;
    end
    if (cmd.fix_en) begin
      hund_r <= (quo_fix > 10'd255) ? 8'd255 : quo_fix[7:0];
      rem_r  <= rem_fix;
    end
  end

  // The estimated quotient is low by at most one, so one compare and subtract corrects it.
  always_comb begin
    quo      = prod100_r[Recip100Shift +: 10];
    quo_x100 = quo * Hundred;
    rem_raw  = {1'b0, mean_r} - quo_x100;
    if (rem_raw[7:0] >= {1'b0, Hundred}) begin
      quo_fix = quo + 10'd1;
      rem_fix = rem_raw[7:0] - {1'b0, Hundred};
    end else begin
      quo_fix = quo;
      rem_fix = rem_raw[7:0];
    end
  end

  assign chk = SubByte + ZeroByte + hund_r + rem_r;

  always_comb begin
    unique case (cmd.byte_idx)
      PosHdr:  frame_sel = HdrByte;
      PosCmd:  frame_sel = CmdByte;
      PosSub:  frame_sel = SubByte;
      PosZero: frame_sel = ZeroByte;
      PosHund: frame_sel = hund_r;
      PosRem:  frame_sel = rem_r;
      PosChk:  frame_sel = chk;
      PosTrl:  frame_sel = TrlByte;
      default: frame_sel = TrlByte;
    endcase
  end

  assign status.show_value     = mode_r;
  assign out_is_frame          = ~mode_r;
  assign out_frame_byte        = mode_r ? 8'd0 : frame_sel;
  assign out_filtered_distance = mode_r ? mean_r : 16'd0;

endmodule

>>> src/tmdf_ctrl.sv
// Controller: sample counting, scan sequencing and result word emission.
module tmdf_ctrl
  import tmdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_last_of_run,
  output tmdf_cmd_t    cmd,
  input  tmdf_status_t status
);

  typedef enum logic [7:0] {
    ST_COLLECT = 8'b0000_0001,
    ST_SCAN    = 8'b0000_0010,
    ST_MID     = 8'b0000_0100,
    ST_DIV     = 8'b0000_1000,
    ST_SPLIT   = 8'b0001_0000,
    ST_HUND    = 8'b0010_0000,
    ST_FIX     = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] count_r, count_nxt;
  logic [2:0] scan_r, scan_nxt;
  logic [2:0] byte_r, byte_nxt;
  logic       in_fire;
  logic       out_fire;
  logic       fifth;
  logic       last;

  assign fifth    = (count_r == 3'(NumSamples - 1));
  // Samples keep coming in while the previous result drains, except the fifth one.
  assign in_ready = (state_r == ST_COLLECT) || ((state_r == ST_EMIT) && !fifth);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (state_r == ST_EMIT);
  assign out_fire  = out_valid && out_ready;
  assign last      = status.show_value || (byte_r == 3'(FrameLen - 1));
  assign out_last_of_run = last;

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    scan_nxt  = scan_r;
    byte_nxt  = byte_r;
    cmd       = '0;
    cmd.byte_idx    = byte_r;
    cmd.load_sample = in_fire;

    if (in_fire) begin
      count_nxt = fifth ? 3'd0 : count_r + 3'd1;
    end

    unique case (state_r)
      ST_COLLECT: begin
        if (in_fire && fifth) begin
          cmd.capture_mode = 1'b1;
          scan_nxt  = 3'd0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_first = (scan_r == 3'd0);
        cmd.scan_step  = 1'b1;
        scan_nxt = scan_r + 3'd1;
        if (scan_r == 3'(NumSamples - 1)) begin
          state_nxt = ST_MID;
        end
      end
      ST_MID: begin
        cmd.mid_en = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        state_nxt  = ST_SPLIT;
      end
      ST_SPLIT: begin
        cmd.split_en = 1'b1;
        byte_nxt     = 3'd0;
        state_nxt    = status.show_value ? ST_EMIT : ST_HUND;
      end
      ST_HUND: begin
        cmd.hund_en = 1'b1;
        state_nxt   = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix_en = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          byte_nxt = byte_r + 3'd1;
          if (last) begin
            state_nxt = ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      count_r <= 3'd0;
      scan_r  <= 3'd0;
      byte_r  <= 3'd0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      scan_r  <= scan_nxt;
      byte_r  <= byte_nxt;
    end
  end

endmodule

>>> src/trimmed_mean_distance_filter.sv
// Top level of the trimmed mean distance filter: controller plus datapath.
// From the fifth sample word to the first result word, the controller steps through
// the scan, middle sum and multiply steps, plus the hundreds multiply and fix in display mode.
// Throughput: one sample word per cycle for the first four words of a group; a group
// then holds off input through scan and multiply, before its one or eight result words.
// Reset: synchronous, active low; clears the sample count and returns to collecting.
module trimmed_mean_distance_filter
  import tmdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_sample_distance,
  input  logic        in_show_on_display,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic [15:0] out_filtered_distance,
  output logic        out_is_frame,
  output logic        out_last_of_run
);

  // The controller counts sample words and, on the fifth, walks the datapath through
  // a scan that finds minimum, maximum and sum. Sum minus the two extremes
  // is the sum of the middle three, so no full sort is needed. Division by three and
  // by one hundred are reciprocal multiplications, each in its own registered stage.
  // While result words drain, the first four samples of the next group are taken in.

  tmdf_cmd_t    cmd;
  tmdf_status_t status;

  tmdf_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_last_of_run (out_last_of_run),
    .cmd             (cmd),
    .status          (status)
  );

  tmdf_datapath u_datapath (
    .clk                   (clk),
    .cmd                   (cmd),
    .status                (status),
    .in_sample_distance    (in_sample_distance),
    .in_show_on_display    (in_show_on_display),
    .out_frame_byte        (out_frame_byte),
    .out_filtered_distance (out_filtered_distance),
    .out_is_frame          (out_is_frame)
  );

endmodule

>>> src/tmdf_checker.sv
// Port-level checker for the trimmed mean distance filter, bound to the top level.
module tmdf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [15:0] in_sample_distance,
  input logic        in_show_on_display,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_frame_byte,
  input logic [15:0] out_filtered_distance,
  input logic        out_is_frame,
  input logic        out_last_of_run
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte) &&
      $stable(out_filtered_distance) && $stable(out_is_frame) && $stable(out_last_of_run))
    else $error("result word changed while stalled");

  // A value word is a single, final word with an empty frame byte.
  a_value_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_frame |-> out_last_of_run && (out_frame_byte == 8'd0))
    else $error("value word malformed");

  // A frame byte carries no distance.
  a_frame_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_frame |-> out_filtered_distance == 16'd0)
    else $error("frame byte carries a distance");

  // Within a frame, the next byte follows at once.
  a_frame_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> out_valid && out_is_frame)
    else $error("frame interrupted");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word after reset");

endmodule

bind trimmed_mean_distance_filter tmdf_checker u_tmdf_checker (.*);

>>> verif/trimmed_mean_distance_filter_tb.sv
// Self-checking testbench for the trimmed mean distance filter.
`timescale 1ns / 100ps

module trimmed_mean_distance_filter_tb;
  import tmdf_pkg::*;

  // Mode bit of the fifth word of a group.
  localparam logic ShowFrame = 1'b0;
  localparam logic ShowValue = 1'b1;

  // Cycles with no word accepted on either side before the run is declared hung.
  localparam int unsigned HangLimit = 2000;
  // Longest stretch from the fifth word to the final frame byte, with margin.
  localparam int unsigned SettleCycles = 40;
  // Length of the deliberate receiver hold-off in the back-pressure test.
  localparam int unsigned HoldOffCycles = 150;

  // Kinds of sample sets used by the random test.
  typedef enum int unsigned {
    SetAnyValue,
    SetShortRange,
    SetNearSaturation,
    SetManyTies,
    SetExtremes
  } sample_set_e;

  typedef logic [15:0] sample_group_t [NumSamples];

  // One result word as the block should present it.
  typedef struct packed {
    logic [7:0]  frame_byte;
    logic [15:0] distance;
    logic        is_frame;
    logic        last;
  } result_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_sample_distance = '0;
  logic        in_show_on_display = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_frame_byte;
  logic [15:0] out_filtered_distance;
  logic        out_is_frame;
  logic        out_last_of_run;

  // Expected result words, oldest first, and the predictor's copy of the sample store.
  result_word_t  pending_results[$];
  sample_group_t gathered_samples;
  int unsigned   gathered_count = 0;

  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  // When set, neither side inserts gaps, so words move back to back.
  bit          steady = 1'b0;
  // A nonzero value asks the receiver to hold off for that many cycles.
  int unsigned hold_request = 0;

  trimmed_mean_distance_filter uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_sample_distance   (in_sample_distance),
    .in_show_on_display   (in_show_on_display),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_frame_byte       (out_frame_byte),
    .out_filtered_distance(out_filtered_distance),
    .out_is_frame         (out_is_frame),
    .out_last_of_run      (out_last_of_run)
  );

  initial begin
    forever begin
      #1 clk = ~clk;
    end
  end

  // Most gaps are zero or a few cycles; now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Track one accepted sample word. The fifth word of a group is sorted together
  // with the four before it, the smallest and largest are dropped, and the
  // middle three are averaged with truncation. The mode bit of that fifth word
  // decides whether one value word or an eight byte display frame follows.
  function automatic void predict_group_result(logic [15:0] sample_value, logic show);
    sample_group_t sorted;
    logic [15:0]   swap;
    logic [17:0]   mid_sum;
    logic [15:0]   mean;
    logic [15:0]   hundreds_full;
    logic [7:0]    hundreds;
    logic [7:0]    remainder;
    logic [7:0]    checksum;
    logic [7:0]    frame [FrameLen];
    result_word_t  word;
    gathered_samples[gathered_count] = sample_value;
    gathered_count++;
    if (gathered_count < NumSamples) return;
    gathered_count = 0;

    sorted = gathered_samples;
    for (int i = 0; i < NumSamples - 1; i++) begin
      for (int j = 0; j < NumSamples - 1 - i; j++) begin
        if (sorted[j] > sorted[j + 1]) begin
          swap = sorted[j];
          sorted[j] = sorted[j + 1];
          sorted[j + 1] = swap;
        end
      end
    end
    mid_sum = 18'(sorted[1]) + 18'(sorted[2]) + 18'(sorted[3]);
    mean = 16'(mid_sum / 18'd3);

    if (show == ShowValue) begin
      word.frame_byte = 8'h00;
      word.distance = mean;
      word.is_frame = 1'b0;
      word.last = 1'b1;
      pending_results.push_back(word);
      return;
    end

    // The hundreds byte saturates once the mean reaches 25600.
    hundreds_full = mean / 16'd100;
    hundreds = (hundreds_full > 16'd255) ? 8'hFF : hundreds_full[7:0];
    remainder = 8'(mean % 16'd100);
    checksum = SubByte + ZeroByte + hundreds + remainder;
    frame = '{HdrByte, CmdByte, SubByte, ZeroByte, hundreds, remainder, checksum, TrlByte};
    for (int k = 0; k < FrameLen; k++) begin
      word.frame_byte = frame[k];
      word.distance = 16'h0000;
      word.is_frame = 1'b1;
      word.last = (k == FrameLen - 1);
      pending_results.push_back(word);
    end
  endfunction

  // Offer one sample word and wait for it to be taken. Valid stays high after
  // acceptance so that a word with no gap follows without a dead cycle; it is
  // only lowered when a gap is wanted or the stimulus ends.
  task automatic send_sample(input logic [15:0] sample_value, input logic show);
    int unsigned gap;
    gap = steady ? 0 : idle_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_sample_distance = sample_value;
    in_show_on_display = show;
    in_valid = 1'b1;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predict_group_result(sample_value, show);
  endtask

  // Send a group of five words. Only the fifth word's mode bit matters; the
  // first four carry the bits of early_bits, which the block should ignore.
  task automatic send_group(input sample_group_t samples, input logic mode,
                            input logic [3:0] early_bits);
    for (int i = 0; i < NumSamples - 1; i++) begin
      send_sample(samples[i], early_bits[i]);
    end
    send_sample(samples[NumSamples - 1], mode);
  endtask

  task automatic report_field(input string name, input int unsigned expected_value,
                              input int unsigned actual_value);
    if (expected_value != actual_value) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected_value, actual_value);
      mismatches++;
    end
  endtask

  // Result checker: each accepted result word is compared with the oldest
  // expectation. Sampling happens at the rising edge, before any register of
  // the block has taken its new value.
  always @(posedge clk) begin
    result_word_t expected_word;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation waiting: frame_byte %0d distance %0d",
               out_frame_byte, out_filtered_distance);
        mismatches++;
      end else begin
        expected_word = pending_results.pop_front();
        report_field("frame_byte", expected_word.frame_byte, out_frame_byte);
        report_field("filtered_distance", expected_word.distance, out_filtered_distance);
        report_field("is_frame", expected_word.is_frame, out_is_frame);
        report_field("last_of_run", expected_word.last, out_last_of_run);
      end
    end
  end

  // Receiver: random stalls, a back-to-back mode, and a long hold-off when asked.
  // The hold-off is counted here, so the sender keeps offering words meanwhile.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (steady) begin
        out_ready = 1'b1;
      end else if (stall_left != 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = idle_gap();
      end
    end
  end

  // Hang detector: ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= HangLimit) begin
        $display("trimmed_mean_distance_filter test failed");
        $finish;
      end
    end
  end

  // Value mode: all zeros, and ties with one low and one full-scale outlier.
  task automatic test_value_mode();
    sample_group_t grp;
    grp = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    send_group(grp, ShowValue, 4'b0000);
    grp = '{16'd7, 16'd7, 16'd3, 16'd7, 16'hFFFF};
    send_group(grp, ShowValue, 4'b1111);
  endtask

  // Display mode: the largest mean, the mean where the hundreds byte first
  // saturates, and the mean just below it, whose checksum wraps past 255.
  // The early mode bits are set, in whole or in part, opposite to the fifth word's to show they are ignored.
  task automatic test_display_mode();
    sample_group_t grp;
    grp = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    send_group(grp, ShowFrame, 4'b1111);
    grp = '{16'd30000, 16'd1, 16'd25600, 16'd25600, 16'd25600};
    send_group(grp, ShowFrame, 4'b0101);
    grp = '{16'd25599, 16'd25599, 16'd25599, 16'd0, 16'hFFFF};
    send_group(grp, ShowFrame, 4'b1010);
  endtask

  function automatic logic [15:0] draw_sample(sample_set_e kind, logic [15:0] anchor);
    case (kind)
      SetShortRange: begin
        return 16'($urandom_range(0, 1200));
      end
      SetNearSaturation: begin
        return 16'($urandom_range(25300, 25900));
      end
      SetManyTies: begin
        return ($urandom_range(0, 1) == 0) ? anchor : 16'($urandom_range(0, 65535));
      end
      SetExtremes: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'($urandom_range(0, 3));
          default: return 16'($urandom_range(65532, 65535));
        endcase
      end
      default: begin
        return 16'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  // Random groups of five with varied sample sets and random mode bits.
  // In every fifteen groups, the last three run back to back on both sides.
  task automatic test_random_groups(input int unsigned group_total);
    sample_group_t grp;
    sample_set_e   kind;
    logic [15:0]   anchor;
    for (int unsigned g = 0; g < group_total; g++) begin
      steady = ((g % 15) >= 12);
      kind = sample_set_e'($urandom_range(0, 4));
      anchor = 16'($urandom_range(0, 65535));
      for (int i = 0; i < NumSamples; i++) begin
        grp[i] = draw_sample(kind, anchor);
      end
      send_group(grp, logic'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
    end
    steady = 1'b0;
  endtask

  // The receiver holds off while the sender offers words back to back, so the
  // block's output backs up and it has to stall its input.
  task automatic test_output_backpressure();
    sample_group_t grp;
    steady = 1'b1;
    hold_request = HoldOffCycles;
    for (int unsigned g = 0; g < 4; g++) begin
      for (int i = 0; i < NumSamples; i++) begin
        grp[i] = 16'($urandom_range(0, 65535));
      end
      send_group(grp, (g == 2) ? ShowValue : ShowFrame, 4'($urandom_range(0, 15)));
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_value_mode();
    test_display_mode();
    test_random_groups(65);
    test_output_backpressure();

    // Stimulus done: lower valid, wait for every expected word, then let the
    // block settle so that any stray result word would still be seen.
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("trimmed_mean_distance_filter test passed");
    end else begin
      $display("trimmed_mean_distance_filter test failed");
    end
    $finish;
  end

endmodule
